>>> rtl/bmru_pkg.sv
// shared types, constants and helper functions for the allocation bitmap engine
package bmru_pkg;

    localparam int MAP_BITS_DEFAULT = 4096;

    localparam int CMD_W   = 3;
    localparam int START_W = 12;
    localparam int COUNT_W = 13;
    localparam int POS_W   = 13;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST      = 3'd0,
        CMD_SET       = 3'd1,
        CMD_CLEAR     = 3'd2,
        CMD_TEST_CLR  = 3'd3,
        CMD_FIND_ZERO = 3'd4,
        CMD_FIND_SET  = 3'd5
    } cmd_t;

    // index of the lowest set bit, zero for an empty word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] y;
        logic [BIT_W-1:0]  idx;
        y   = x & (~x + WORD_W'(1));
        idx = '0;
        for (int j = 0; j < WORD_W; j++)
        begin
            if (y[j])
            begin
                idx = idx | BIT_W'(j);
            end
        end
        return idx;
    endfunction

endpackage

>>> rtl/bmru_ram.sv
// generic simple dual-port ram with registered read
module bmru_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/bitmap_range_update_and_search.sv
// top level of the allocation bitmap engine: command sequencer around the word memory
//
// The bitmap lives in one word memory, 32 bits a word, walked one word per
// cycle by a read-modify-write sequencer. After acceptance an item walks the
// words its range or search touches, then a finishing state hands over the
// result and the next item may be accepted (a test reads one word, an empty
// range or failed-at-start search skips the walk); a search stops at the word
// holding the first hit. The single memory port pair sets the one-word-per-cycle
// walk. After reset a clearing pass writes every word to zero, and no item is
// accepted until it ends. The result register frees the sequencer as soon as a
// result is handed over.
module bitmap_range_update_and_search #(
    parameter int MAP_BITS = bmru_pkg::MAP_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bmru_pkg::CMD_W-1:0]    cmd,
    input  logic [bmru_pkg::START_W-1:0]  start_index,
    input  logic [bmru_pkg::COUNT_W-1:0]  count,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bmru_pkg::POS_W-1:0]    position,
    output logic                          found,
    output logic                          bit_value
);

    localparam int WORDS = MAP_BITS / bmru_pkg::WORD_W;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int END_W = ($clog2(MAP_BITS + 1) > 14) ? $clog2(MAP_BITS + 1) : 14;
    localparam logic [END_W-1:0] MAP_END = END_W'(MAP_BITS);
    localparam logic [WA_W-1:0]  LAST_WORD = WA_W'(WORDS - 1);

    localparam int WW = bmru_pkg::WORD_W;
    localparam int BW = bmru_pkg::BIT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROC,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [WA_W-1:0]                 clr_reg, clr_next;
    bmru_pkg::cmd_t                  cmd_reg, cmd_next;
    logic [bmru_pkg::START_W-1:0]    s_reg, s_next;
    logic [bmru_pkg::COUNT_W-1:0]    lim_reg, lim_next;
    logic [END_W-1:0]                e_last_reg, e_last_next;
    logic [WA_W-1:0]                 cur_w_reg, cur_w_next;
    logic [WA_W-1:0]                 last_w_reg, last_w_next;
    logic [bmru_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                            fnd_reg, fnd_next;
    logic                            bv_reg, bv_next;

    logic                            out_valid_reg, out_valid_next;
    logic [bmru_pkg::POS_W-1:0]      position_reg, position_next;
    logic                            found_reg, found_next;
    logic                            bit_value_reg, bit_value_next;

    logic                ram_we;
    logic [WA_W-1:0]     ram_waddr;
    logic [WW-1:0]       ram_wdata;
    logic [WA_W-1:0]     ram_raddr;
    logic [WW-1:0]       ram_rdata;

    logic [END_W-1:0]    s_ext, cnt_ext, sum, t1, e_acc, e_m1;
    bmru_pkg::cmd_t      cmd_in;
    logic                trivial;
    logic [WA_W-1:0]     first_w;
    logic [BW-1:0]       lo, hi;
    logic [WW-1:0]       mask, zb, hb;
    logic                is_last, out_free;
    logic [END_W-1:0]    zpos, hpos;

    bmru_ram #(
        .WIDTH (WW),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign position  = position_reg;
    assign found     = found_reg;
    assign bit_value = bit_value_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // decode of the incoming item
    always_comb
    begin
        s_ext   = END_W'(start_index);
        cnt_ext = END_W'(count);
        sum     = s_ext + cnt_ext;
        t1      = s_ext + END_W'(1);
        cmd_in  = bmru_pkg::cmd_t'(cmd);
        unique case (cmd_in)
            bmru_pkg::CMD_TEST:
            begin
                e_acc = (t1 > MAP_END) ? MAP_END : t1;
            end
            bmru_pkg::CMD_SET, bmru_pkg::CMD_CLEAR, bmru_pkg::CMD_TEST_CLR:
            begin
                e_acc = (sum > MAP_END) ? MAP_END : sum;
            end
            bmru_pkg::CMD_FIND_ZERO, bmru_pkg::CMD_FIND_SET:
            begin
                e_acc = (cnt_ext > MAP_END) ? MAP_END : cnt_ext;
            end
            default:
            begin
                e_acc = '0;
            end
        endcase
        trivial = (s_ext >= e_acc);
        e_m1    = e_acc - END_W'(1);
    end

    // word masks for the word now on the read port
    always_comb
    begin
        first_w = WA_W'(END_W'(s_reg) >> BW);
        is_last = (cur_w_reg == last_w_reg);
        lo      = (cur_w_reg == first_w) ? s_reg[BW-1:0] : '0;
        hi      = is_last ? e_last_reg[BW-1:0] : BW'(WW - 1);
        mask    = ({WW{1'b1}} << lo) & ({WW{1'b1}} >> (BW'(WW - 1) - hi));
        zb      = ~ram_rdata & mask;
        hb      = ((cmd_reg == bmru_pkg::CMD_FIND_SET) ? ram_rdata : ~ram_rdata) & mask;
        zpos    = END_W'({cur_w_reg, bmru_pkg::lowest_set(zb)});
        hpos    = END_W'({cur_w_reg, bmru_pkg::lowest_set(hb)});
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        s_next         = s_reg;
        lim_next       = lim_reg;
        e_last_next    = e_last_reg;
        cur_w_next     = cur_w_reg;
        last_w_next    = last_w_reg;
        pos_next       = pos_reg;
        fnd_next       = fnd_reg;
        bv_next        = bv_reg;
        out_valid_next = out_valid_reg && out_stall;
        position_next  = position_reg;
        found_next     = found_reg;
        bit_value_next = bit_value_reg;
        ram_we         = 1'b0;
        ram_waddr      = cur_w_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = cur_w_reg + WA_W'(1);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + WA_W'(1);
                if (clr_reg == LAST_WORD)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                ram_raddr = WA_W'(s_ext >> BW);
                if (in_valid)
                begin
                    cmd_next    = cmd_in;
                    s_next      = start_index;
                    lim_next    = count;
                    e_last_next = e_m1;
                    cur_w_next  = WA_W'(s_ext >> BW);
                    last_w_next = WA_W'(e_m1 >> BW);
                    fnd_next    = 1'b0;
                    bv_next     = 1'b0;
                    pos_next    = '0;
                    if (trivial)
                    begin
                        if (cmd_in == bmru_pkg::CMD_FIND_ZERO ||
                            cmd_in == bmru_pkg::CMD_FIND_SET)
                        begin
                            pos_next = count;
                        end
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_PROC;
                    end
                end
            end
            ST_PROC:
            begin
                cur_w_next = cur_w_reg + WA_W'(1);
                unique case (cmd_reg)
                    bmru_pkg::CMD_TEST:
                    begin
                        bv_next    = ram_rdata[s_reg[BW-1:0]];
                        state_next = ST_FIN;
                    end
                    bmru_pkg::CMD_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | mask;
                        if (is_last)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    bmru_pkg::CMD_CLEAR, bmru_pkg::CMD_TEST_CLR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~mask;
                        if (cmd_reg == bmru_pkg::CMD_TEST_CLR && !fnd_reg && (zb != '0))
                        begin
                            fnd_next = 1'b1;
                            pos_next = zpos[bmru_pkg::POS_W-1:0];
                        end
                        if (is_last)
                        begin
                            state_next = ST_FIN;
                        end
                    end
                    bmru_pkg::CMD_FIND_ZERO, bmru_pkg::CMD_FIND_SET:
                    begin
                        if (hb != '0)
                        begin
                            fnd_next   = 1'b1;
                            pos_next   = hpos[bmru_pkg::POS_W-1:0];
                            state_next = ST_FIN;
                        end
                        else if (is_last)
                        begin
                            pos_next   = lim_reg;
                            state_next = ST_FIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FIN;
                    end
                endcase
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    position_next  = pos_reg;
                    found_next     = fnd_reg;
                    bit_value_next = bv_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        s_reg         <= s_next;
        lim_reg       <= lim_next;
        e_last_reg    <= e_last_next;
        cur_w_reg     <= cur_w_next;
        last_w_reg    <= last_w_next;
        pos_reg       <= pos_next;
        fnd_reg       <= fnd_next;
        bv_reg        <= bv_next;
        position_reg  <= position_next;
        found_reg     <= found_next;
        bit_value_reg <= bit_value_next;
    end

endmodule

>>> rtl/bmru_checker.sv
// port-level checker for the allocation bitmap engine, bound to the top level
module bmru_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [bmru_pkg::CMD_W-1:0]    cmd,
    input logic [bmru_pkg::START_W-1:0]  start_index,
    input logic [bmru_pkg::COUNT_W-1:0]  count,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [bmru_pkg::POS_W-1:0]    position,
    input logic                          found,
    input logic                          bit_value
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) &&
        $stable(found) && $stable(bit_value))
    else $error("stalled result changed");

    // a tested bit carries no position and no found flag
    a_bit_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bit_value |-> !found && (position == '0))
    else $error("bit value with position or found");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
    else $error("item accepted while busy");

endmodule

bind bitmap_range_update_and_search bmru_checker u_bmru_checker (.*);

>>> tb/bitmap_range_update_and_search_checker.sv
// checker for the allocation bitmap engine: keeps its own bitmap, predicts and compares results
module bitmap_range_update_and_search_checker
    import bmru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [CMD_W-1:0]   cmd,
    input  logic [START_W-1:0] start_index,
    input  logic [COUNT_W-1:0] count,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [POS_W-1:0]   position,
    input  logic               found,
    input  logic               bit_value,
    output int                 mismatches,
    output int                 outstanding
);

    localparam int MAP_BITS   = MAP_BITS_DEFAULT;
    localparam int WORD_COUNT = (MAP_BITS + 31) / 32;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             found;
        logic             bit_value;
    } outcome_t;

    logic [WORD_W-1:0] map_words [WORD_COUNT];
    outcome_t          pending_outcomes [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic logic map_bit(input int i);
        if (i >= MAP_BITS)
        begin
            return 1'b0;
        end
        return map_words[i / 32][i % 32];
    endfunction

    function automatic void fill_bits(input int first, input int stop, input logic v);
        for (int i = first; i < stop; i++)
        begin
            map_words[i / 32][i % 32] = v;
        end
    endfunction

    function automatic outcome_t apply_command(input logic [CMD_W-1:0] op,
                                               input logic [START_W-1:0] first,
                                               input logic [COUNT_W-1:0] amount);
        outcome_t r;
        int       stop;
        logic     want;
        r    = '0;
        stop = int'(first) + int'(amount);
        if (stop > MAP_BITS)
        begin
            stop = MAP_BITS;
        end
        case (op)
            CMD_TEST:
            begin
                r.bit_value = map_bit(int'(first));
            end
            CMD_SET:
            begin
                fill_bits(int'(first), stop, 1'b1);
            end
            CMD_CLEAR:
            begin
                fill_bits(int'(first), stop, 1'b0);
            end
            CMD_TEST_CLR:
            begin
                for (int i = int'(first); i < stop && !r.found; i++)
                begin
                    if (!map_bit(i))
                    begin
                        r.position = POS_W'(i);
                        r.found    = 1'b1;
                    end
                end
                fill_bits(int'(first), stop, 1'b0);
            end
            CMD_FIND_ZERO, CMD_FIND_SET:
            begin
                want       = (op == CMD_FIND_SET);
                stop       = (int'(amount) > MAP_BITS) ? MAP_BITS : int'(amount);
                r.position = amount;
                for (int i = int'(first); i < stop && !r.found; i++)
                begin
                    if (map_bit(i) == want)
                    begin
                        r.position = POS_W'(i);
                        r.found    = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        int       errs;
        if (!rst_n)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
            begin
                map_words[w] = '0;
            end
            pending_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (in_valid && !in_stall)
            begin
                pending_outcomes.push_back(apply_command(cmd, start_index, count));
            end
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $error("result with no item waiting: position %0d found %0d bit_value %0d",
                           position, found, bit_value);
                    errs++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (position !== want.position)
                    begin
                        $error("position: expected %0d, got %0d", want.position, position);
                        errs++;
                    end
                    if (found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, found);
                        errs++;
                    end
                    if (bit_value !== want.bit_value)
                    begin
                        $error("bit_value: expected %0d, got %0d", want.bit_value, bit_value);
                        errs++;
                    end
                end
            end
            if (errs != 0)
            begin
                mismatches <= mismatches + errs;
            end
            outstanding <= pending_outcomes.size();
        end
    end

endmodule

>>> tb/bitmap_range_update_and_search_test.sv
// testbench top for the allocation bitmap engine: clock, reset, stimulus and verdict
module bitmap_range_update_and_search_test;
    import bmru_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 1000000;

    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_stall;
    logic [CMD_W-1:0]   cmd         = '0;
    logic [START_W-1:0] start_index = '0;
    logic [COUNT_W-1:0] count       = '0;
    logic               out_valid;
    logic               out_stall   = 1'b0;
    logic [POS_W-1:0]   position;
    logic               found;
    logic               bit_value;

    int   mismatches;
    int   outstanding;
    int   cycles    = 0;
    int   hold_left = 0;
    logic steady    = 1'b0;

    bitmap_range_update_and_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .start_index (start_index),
        .count       (count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .found       (found),
        .bit_value   (bit_value)
    );

    bitmap_range_update_and_search_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .start_index (start_index),
        .count       (count),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .position    (position),
        .found       (found),
        .bit_value   (bit_value),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45)
        begin
            return 0;
        end
        if (roll < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // receiver stalls in runs of random length
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
        else
        begin
            hold_left <= pick_gap();
            out_stall <= !steady && ($urandom_range(0, 2) == 0);
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic [CMD_W-1:0] op, input logic [START_W-1:0] first,
                             input logic [COUNT_W-1:0] amount);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= op;
        start_index <= first;
        count       <= amount;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        @(negedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] range_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
        begin
            return COUNT_W'($urandom_range(0, 40));
        end
        if (roll < 85)
        begin
            return COUNT_W'($urandom_range(0, 300));
        end
        if (roll < 97)
        begin
            return COUNT_W'($urandom_range(0, 4096));
        end
        return COUNT_W'($urandom_range(4097, 8191));
    endfunction

    function automatic logic [COUNT_W-1:0] search_limit(input int first);
        int roll;
        int lim;
        roll = $urandom_range(0, 99);
        if (roll < 50)
        begin
            lim = first + $urandom_range(0, 400);
            return COUNT_W'((lim > 8191) ? 8191 : lim);
        end
        if (roll < 75)
        begin
            return COUNT_W'($urandom_range(0, 4096));
        end
        if (roll < 90)
        begin
            return COUNT_W'(4096);
        end
        return COUNT_W'($urandom_range(4097, 8191));
    endfunction

    initial
    begin
        int               roll;
        int               first;
        logic [CMD_W-1:0] op;
        logic [COUNT_W-1:0] amount;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // directed items
        send_item(CMD_TEST,      12'd0,    13'd0);
        send_item(CMD_FIND_ZERO, 12'd0,    13'd4096);
        send_item(CMD_FIND_SET,  12'd0,    13'd4096);
        send_item(CMD_SET,       12'd0,    13'd4096);
        send_item(CMD_TEST,      12'd4095, 13'd8191);
        send_item(CMD_FIND_ZERO, 12'd0,    13'd4096);
        send_item(CMD_TEST_CLR,  12'd4090, 13'd100);
        send_item(CMD_TEST_CLR,  12'd4090, 13'd100);
        send_item(CMD_CLEAR,     12'd5,    13'd70);
        send_item(CMD_FIND_ZERO, 12'd3,    13'd8191);
        send_item(CMD_FIND_SET,  12'd4000, 13'd4000);
        send_item(CMD_FIND_SET,  12'd100,  13'd50);
        send_item(CMD_SET,       12'd10,   13'd0);
        send_item(CMD_TEST_CLR,  12'd10,   13'd0);
        send_item(CMD_SPARE_A,   12'd4095, 13'd8191);
        send_item(CMD_SPARE_B,   12'd0,    13'd0);
        send_item(CMD_FIND_ZERO, 12'd75,   13'd8191);
        send_item(CMD_FIND_SET,  12'd4095, 13'd8191);
        send_item(CMD_CLEAR,     12'd0,    13'd4096);
        send_item(CMD_FIND_SET,  12'd0,    13'd5000);
        send_item(CMD_SET,       12'd4064, 13'd32);
        send_item(CMD_FIND_SET,  12'd0,    13'd4096);
        send_item(CMD_TEST_CLR,  12'd4060, 13'd8191);
        send_item(CMD_FIND_ZERO, 12'd4095, 13'd4096);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 100 == 0)
            begin
                steady = ($urandom_range(0, 3) == 0);
            end
            roll  = $urandom_range(0, 99);
            first = $urandom_range(0, 4095);
            if (roll < 22)
            begin
                op = CMD_SET;
            end
            else if (roll < 34)
            begin
                op = CMD_CLEAR;
            end
            else if (roll < 46)
            begin
                op = CMD_TEST_CLR;
            end
            else if (roll < 62)
            begin
                op = CMD_FIND_ZERO;
            end
            else if (roll < 78)
            begin
                op = CMD_FIND_SET;
            end
            else if (roll < 96)
            begin
                op = CMD_TEST;
            end
            else
            begin
                op = $urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B;
            end
            if (op == CMD_FIND_ZERO || op == CMD_FIND_SET)
            begin
                amount = search_limit(first);
            end
            else if (op == CMD_TEST || op == CMD_SPARE_A || op == CMD_SPARE_B)
            begin
                amount = COUNT_W'($urandom_range(0, 8191));
            end
            else
            begin
                amount = range_length();
            end
            send_item(op, START_W'(first), amount);
        end
        in_valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
